### src/crfe_pkg.sv
// Shared constants for the clipped rectangle fill engine.
`timescale 1ns / 1ps

package crfe_pkg;

   // command codes
   localparam logic [2:0] OP_PUT     = 3'd0;
   localparam logic [2:0] OP_GET     = 3'd1;
   localparam logic [2:0] OP_CLEAR   = 3'd2;
   localparam logic [2:0] OP_FILL    = 3'd3;
   localparam logic [2:0] OP_OUTLINE = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_DRAW_ENABLE  = 2'd2;

   // store geometry defaults
   localparam int DEFAULT_MAX_WIDTH  = 128;
   localparam int DEFAULT_MAX_HEIGHT = 128;

endpackage

### src/clipped_rect_fill_engine_unit.sv
// Clipped rectangle fill engine: command sequencer, pixel store and result register.
// Steps: put/fill/clear take a clip state, then one pixel written per cycle by the
//   shared address adder, then a hand-off state; outline runs four clipped fills back to
//   back, each a clip state plus its pixels, then the hand-off; get takes clip, run, read
//   wait, hand-off (clip, hand-off outside the frame); disabled/unknown ops only hand off.
// Throughput: one item at a time; the next item is taken once the sequencer is back in
//   idle, while a finished result may still wait in the output register.
// Reset: synchronous, active high; then a clearing pass writes zero to every store word,
//   one word per cycle, with no item taken meanwhile.
`timescale 1ns / 1ps

module clipped_rect_fill_engine_unit
   import crfe_pkg::*;
#(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   // configuration writes
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   // command items
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [15:0] req_pos_x,
   input  logic [15:0] req_pos_y,
   input  logic [15:0] req_box_width,
   input  logic [15:0] req_box_height,
   input  logic [31:0] req_color,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_color,
   output logic        rsp_in_bounds
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   // frame registers are 8 bits wide, so the usable frame never exceeds 255
   localparam logic [7:0] WCAP = (MAX_WIDTH > 255) ? 8'd255 : 8'(MAX_WIDTH);
   localparam logic [7:0] HCAP = (MAX_HEIGHT > 255) ? 8'd255 : 8'(MAX_HEIGHT);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   // sequencer states
   localparam logic [2:0] ST_CLR    = 3'd0;  // clearing pass after reset
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_CLIP   = 3'd2;  // clip one segment, form its first address
   localparam logic [2:0] ST_RUN    = 3'd3;  // one pixel per cycle
   localparam logic [2:0] ST_RDWAIT = 3'd4;  // store read data lands
   localparam logic [2:0] ST_DONE   = 3'd5;  // hand result to output register

   logic [2:0]    state_ff, state_in;

   // configuration
   logic [7:0]    frame_width_ff, frame_height_ff;
   logic          draw_enable_ff;
   logic [7:0]    fw, fh;

   // captured command
   logic [2:0]    op_ff, op_in;
   logic [15:0]   x_ff, y_ff, w_ff, h_ff;
   logic [31:0]   color_ff;

   // current segment (outline runs four of them)
   logic [1:0]    seg_ff, seg_in;
   logic [16:0]   sx_ff, sx_in, sy_ff, sy_in;
   logic [15:0]   sw_ff, sw_in, sh_ff, sh_in;

   // pixel walk
   logic [AW-1:0] row_ff, row_in;
   logic [7:0]    col_ff, col_in, rowc_ff, rowc_in;
   logic [7:0]    cw_ff, cw_in, ch_ff, ch_in;
   logic [AW-1:0] clr_ff, clr_in;

   // result
   logic [31:0]   res_color_ff, res_color_in;
   logic          res_hit_ff, res_hit_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_color_ff;
   logic          rsp_hit_ff;

   // store
   logic [31:0]   mem [DEPTH];
   logic [31:0]   rd_data_ff;
   logic [AW-1:0] mem_addr;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic          wr_en;

   // clip logic
   logic          in_frame;
   logic [17:0]   x_end, y_end;
   logic [7:0]    cw_clip, ch_clip;
   logic          seg_ok;
   logic          last_col, last_pix;
   logic          accept, rsp_free;

   assign fw = (frame_width_ff  > WCAP) ? WCAP : frame_width_ff;
   assign fh = (frame_height_ff > HCAP) ? HCAP : frame_height_ff;

   assign req_stall      = (state_ff != ST_IDLE);
   assign accept         = req_valid && !req_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_color = rsp_color_ff;
   assign rsp_in_bounds  = rsp_hit_ff;
   assign rsp_free       = !rsp_valid_ff || !rsp_stall;

   // Segment clip: start must sit inside the frame, extent is cut at the edge.
   always_comb begin
      in_frame = (sx_ff < {9'b0, fw}) && (sy_ff < {9'b0, fh});
      x_end    = {1'b0, sx_ff} + {2'b0, sw_ff};
      y_end    = {1'b0, sy_ff} + {2'b0, sh_ff};
      cw_clip  = (x_end > {10'b0, fw}) ? 8'(fw - sx_ff[7:0]) : sw_ff[7:0];
      ch_clip  = (y_end > {10'b0, fh}) ? 8'(fh - sy_ff[7:0]) : sh_ff[7:0];
      seg_ok   = in_frame && (cw_clip != 8'd0) && (ch_clip != 8'd0);
   end

   // the shared address adder: row start plus column
   assign mem_addr = row_ff + AW'(col_ff);
   assign last_col = (col_ff == cw_ff - 8'd1);
   assign last_pix = last_col && (rowc_ff == ch_ff - 8'd1);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      seg_in       = seg_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      sw_in        = sw_ff;
      sh_in        = sh_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      rowc_in      = rowc_ff;
      cw_in        = cw_ff;
      ch_in        = ch_ff;
      clr_in       = clr_ff;
      res_color_in = res_color_ff;
      res_hit_in   = res_hit_ff;
      wr_en        = 1'b0;
      wr_addr      = mem_addr;
      wr_data      = color_ff;

      unique case (state_ff)
         ST_CLR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = 32'd0;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in        = req_op;
               seg_in       = 2'd0;
               res_color_in = 32'd0;
               res_hit_in   = 1'b0;
               sx_in        = {1'b0, req_pos_x};
               sy_in        = {1'b0, req_pos_y};
               sw_in        = 16'd1;
               sh_in        = 16'd1;
               state_in     = ST_CLIP;
               if (!draw_enable_ff) begin
                  state_in = ST_DONE;
               end else begin
                  case (req_op) inside
                     OP_PUT, OP_GET: begin
                     end
                     OP_CLEAR: begin
                        // clear is a fill of the whole frame at pitch fw
                        sx_in = 17'd0;
                        sy_in = 17'd0;
                        sw_in = {8'b0, fw};
                        sh_in = {8'b0, fh};
                     end
                     OP_FILL: begin
                        sw_in = req_box_width;
                        sh_in = req_box_height;
                     end
                     OP_OUTLINE: begin
                        // top edge first
                        sw_in = req_box_width;
                        if (req_box_width == 16'd0 || req_box_height == 16'd0) begin
                           state_in = ST_DONE;
                        end
                     end
                     default: state_in = ST_DONE;
                  endcase
               end
            end
         end
         ST_CLIP: begin
            if (seg_ok) begin
               res_hit_in = 1'b1;
               row_in     = AW'({8'b0, sy_ff[7:0]} * {8'b0, fw} + {8'b0, sx_ff[7:0]});
               col_in     = 8'd0;
               rowc_in    = 8'd0;
               cw_in      = cw_clip;
               ch_in      = ch_clip;
               state_in   = ST_RUN;
            end else if (op_ff == OP_OUTLINE && seg_ff != 2'd3) begin
               state_in = ST_CLIP;
               seg_in   = seg_ff + 2'd1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RUN: begin
            if (op_ff == OP_GET) begin
               state_in = ST_RDWAIT;
            end else begin
               wr_en = 1'b1;
               if (last_pix) begin
                  if (op_ff == OP_OUTLINE && seg_ff != 2'd3) begin
                     state_in = ST_CLIP;
                     seg_in   = seg_ff + 2'd1;
                  end else begin
                     state_in = ST_DONE;
                  end
               end else if (last_col) begin
                  col_in  = 8'd0;
                  rowc_in = rowc_ff + 8'd1;
                  row_in  = row_ff + AW'(fw);
               end else begin
                  col_in = col_ff + 8'd1;
               end
            end
         end
         ST_RDWAIT: begin
            res_color_in = rd_data_ff;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // outline segments: bottom, left, right
      if (seg_in != seg_ff) begin
         unique case (seg_in)
            2'd1: begin
               sx_in = {1'b0, x_ff};
               sy_in = {1'b0, y_ff} + {1'b0, h_ff} - 17'd1;
               sw_in = w_ff;
               sh_in = 16'd1;
            end
            2'd2: begin
               sx_in = {1'b0, x_ff};
               sy_in = {1'b0, y_ff};
               sw_in = 16'd1;
               sh_in = h_ff;
            end
            2'd3: begin
               sx_in = {1'b0, x_ff} + {1'b0, w_ff} - 17'd1;
               sy_in = {1'b0, y_ff};
               sw_in = 16'd1;
               sh_in = h_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLR;
         clr_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         frame_width_ff  <= 8'd0;
         frame_height_ff <= 8'd0;
         draw_enable_ff  <= 1'b0;
         seg_ff          <= 2'd0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         seg_ff       <= seg_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data;
               CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
               CSR_DRAW_ENABLE:  draw_enable_ff  <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload and walk registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      sw_ff        <= sw_in;
      sh_ff        <= sh_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      rowc_ff      <= rowc_in;
      cw_ff        <= cw_in;
      ch_ff        <= ch_in;
      res_color_ff <= res_color_in;
      res_hit_ff   <= res_hit_in;
      if (accept) begin
         x_ff     <= req_pos_x;
         y_ff     <= req_pos_y;
         w_ff     <= req_box_width;
         h_ff     <= req_box_height;
         color_ff <= req_color;
      end
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_color_ff <= res_color_ff;
         rsp_hit_ff   <= res_hit_ff;
      end
   end

   // pixel store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[mem_addr];
   end

   // no result may appear while the store is still being cleared
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLR) |-> !rsp_valid_ff)
      else $error("result during clearing pass");

   // pixel walk stays inside the clipped box
   a_walk_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && op_ff != OP_GET) |-> (col_ff < cw_ff) && (rowc_ff < ch_ff))
      else $error("pixel walk left clipped box");

   // a command that touched the frame was run with drawing enabled
   a_hit_needs_enable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && res_hit_ff) |-> draw_enable_ff)
      else $error("in-bounds result while disabled");

   // an accepted item always leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("sequencer stayed idle after accept");

endmodule

### tb/sv/tb_clipped_rect_fill_engine_unit.sv
// Self-checking testbench for the clipped rectangle fill engine.
`timescale 1ns / 1ps

module tb_clipped_rect_fill_engine_unit;
   import crfe_pkg::*;

   // opcodes the engine must ignore, and the register index with no register behind it
   localparam logic [2:0] OP_SPARE_LO  = 3'd5;
   localparam logic [2:0] OP_SPARE_MID = 3'd6;
   localparam logic [2:0] OP_SPARE_HI  = 3'd7;
   localparam logic [1:0] CSR_SPARE    = 2'd3;

   localparam int unsigned STORE_W     = DEFAULT_MAX_WIDTH;
   localparam int unsigned STORE_H     = DEFAULT_MAX_HEIGHT;
   localparam int unsigned STORE_WORDS = STORE_W * STORE_H;

   // A full-frame clear writes every store word, and so does the clearing pass after reset.
   // The watchdog idle limit is set well above either, with nothing moving on any port.
   localparam int unsigned IDLE_LIMIT  = 100000;
   localparam int unsigned TAIL_CYCLES = 64;
   localparam int unsigned SHOW_LIMIT  = 10;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] w;
      logic [15:0] h;
      logic [31:0] color;
   } draw_cmd_type;

   typedef struct packed {
      logic [31:0] read_color;
      logic        in_bounds;
   } pixel_rsp_type;

   typedef enum logic [2:0] {
      TRAFFIC_PIXEL,
      TRAFFIC_RECT,
      TRAFFIC_OUTLINE,
      TRAFFIC_MIX,
      TRAFFIC_NOISE
   } traffic_type;

   // receiver backpressure styles, re-picked at random by the reply checker
   typedef enum logic [1:0] {
      DRAIN_FREE,
      DRAIN_COIN,
      DRAIN_HEAVY,
      DRAIN_BLOCKS
   } drain_mode_type;

   // ---------------------------------------------------------------- DUT ports
   logic        clock;
   logic        reset          = 1'b1;
   logic        csr_write      = 1'b0;
   logic [1:0]  csr_index      = '0;
   logic [7:0]  csr_data       = '0;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [2:0]  req_op         = '0;
   logic [15:0] req_pos_x      = '0;
   logic [15:0] req_pos_y      = '0;
   logic [15:0] req_box_width  = '0;
   logic [15:0] req_box_height = '0;
   logic [31:0] req_color      = '0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [31:0] rsp_read_color;
   logic        rsp_in_bounds;

   clipped_rect_fill_engine_unit dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_box_width  (req_box_width),
      .req_box_height (req_box_height),
      .req_color      (req_color),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_color (rsp_read_color),
      .rsp_in_bounds  (rsp_in_bounds)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- shadow of the engine
   // Our own copy of the pixel store and of the three registers. Updated at the edge an
   // item or a register write is taken, so it always reflects what the engine should hold.
   logic [31:0] frame_image [STORE_WORDS];
   logic [7:0]  shadow_width  = '0;
   logic [7:0]  shadow_height = '0;
   logic        shadow_enable = 1'b0;

   pixel_rsp_type predicted_replies [$];

   int unsigned fail_count      = 0;
   int unsigned items_sent      = 0;
   int unsigned reads_sent      = 0;
   int unsigned replies_checked = 0;
   int unsigned frame_settings  = 0;
   int unsigned burst_left      = 0;

   initial begin
      for (int unsigned i = 0; i < STORE_WORDS; i++) frame_image[i] = '0;
   end

   // oversized registers saturate at the store geometry
   function automatic int unsigned visible_width();
      return (shadow_width > STORE_W) ? STORE_W : shadow_width;
   endfunction

   function automatic int unsigned visible_height();
      return (shadow_height > STORE_H) ? STORE_H : shadow_height;
   endfunction

   // One clipped fill; returns 1 when at least one pixel lands in the frame.
   function automatic bit paint_box(input int unsigned x, y, w, h, input logic [31:0] c);
      int unsigned fw;
      int unsigned fh;
      int unsigned addr;
      fw = visible_width();
      fh = visible_height();
      if (x >= fw || y >= fh) return 1'b0;
      if (x + w > fw) w = fw - x;
      if (y + h > fh) h = fh - y;
      for (int unsigned j = 0; j < h; j++) begin
         for (int unsigned i = 0; i < w; i++) begin
            addr = (y + j) * fw + x + i;
            if (addr < STORE_WORDS) frame_image[addr] = c;
         end
      end
      return (w != 0 && h != 0);
   endfunction

   // Applies one command to the shadow store and returns the reply it must produce.
   function automatic pixel_rsp_type paint_and_predict(input draw_cmd_type c);
      pixel_rsp_type r;
      int unsigned   fw;
      int unsigned   fh;
      int unsigned   px;
      int unsigned   py;
      int unsigned   pw;
      int unsigned   ph;
      int unsigned   addr;
      bit            top, bottom, left, right;
      r  = '0;
      fw = visible_width();
      fh = visible_height();
      px = c.x;
      py = c.y;
      pw = c.w;
      ph = c.h;
      if (shadow_enable) begin
         case (c.op) inside
            OP_PUT, OP_GET: begin
               if (px < fw && py < fh) begin
                  addr = py * fw + px;
                  if (c.op == OP_PUT) frame_image[addr] = c.color;
                  else r.read_color = frame_image[addr];
                  r.in_bounds = 1'b1;
               end
            end
            OP_CLEAR: begin
               for (int unsigned i = 0; i < fw * fh; i++) frame_image[i] = c.color;
               r.in_bounds = (fw * fh != 0);
            end
            OP_FILL: begin
               r.in_bounds = paint_box(px, py, pw, ph, c.color);
            end
            OP_OUTLINE: begin
               if (pw != 0 && ph != 0) begin
                  top    = paint_box(px, py, pw, 1, c.color);
                  bottom = paint_box(px, py + ph - 1, pw, 1, c.color);
                  left   = paint_box(px, py, 1, ph, c.color);
                  right  = paint_box(px + pw - 1, py, 1, ph, c.color);
                  r.in_bounds = top | bottom | left | right;
               end
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   function automatic void flag_error(input string msg);
      if (fail_count < SHOW_LIMIT) $display("ERROR: %s", msg);
      fail_count++;
   endfunction

   // ---------------------------------------------------------------- reply checker
   // Samples the reply port at each edge, then picks the stall for the next cycle.
   pixel_rsp_type  owed;
   drain_mode_type drain_mode = DRAIN_FREE;
   int unsigned    stall_tick = 0;

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (predicted_replies.size() == 0) begin
            flag_error($sformatf("reply with no command pending: read_color %08h in_bounds %b",
                                 rsp_read_color, rsp_in_bounds));
         end else begin
            owed = predicted_replies.pop_front();
            if (rsp_read_color !== owed.read_color)
               flag_error($sformatf("reply %0d read_color: expected %08h, got %08h",
                                    replies_checked, owed.read_color, rsp_read_color));
            if (rsp_in_bounds !== owed.in_bounds)
               flag_error($sformatf("reply %0d in_bounds: expected %b, got %b",
                                    replies_checked, owed.in_bounds, rsp_in_bounds));
         end
         replies_checked++;
      end
      if (stall_tick % 256 == 0) drain_mode = drain_mode_type'($urandom_range(0, 3));
      stall_tick++;
      case (drain_mode)
         DRAIN_FREE:  rsp_stall <= 1'b0;
         DRAIN_COIN:  rsp_stall <= ($urandom_range(0, 1) == 0);
         DRAIN_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= ((stall_tick % 32) < 20);
      endcase
   end

   // ---------------------------------------------------------------- watchdog
   // Counts cycles with no traffic on any port; a hung engine ends the run here.
   initial begin : watchdog
      int unsigned idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
            idle = 0;
         else
            idle++;
      end
      $display("watchdog: no traffic for %0d cycles, %0d replies still owed",
               IDLE_LIMIT, predicted_replies.size());
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus helpers
   function automatic draw_cmd_type draw_item(input logic [2:0] op,
                                              input logic [15:0] x, y, w, h,
                                              input logic [31:0] color);
      draw_cmd_type c;
      c.op    = op;
      c.x     = x;
      c.y     = y;
      c.w     = w;
      c.h     = h;
      c.color = color;
      return c;
   endfunction

   // Offers one item, holds it through stalls, and records the reply it must produce.
   // Valid stays high across a burst; a gap is only inserted between bursts.
   task automatic send_cmd(input draw_cmd_type c);
      int unsigned gap;
      req_valid      <= 1'b1;
      req_op         <= c.op;
      req_pos_x      <= c.x;
      req_pos_y      <= c.y;
      req_box_width  <= c.w;
      req_box_height <= c.h;
      req_color      <= c.color;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted_replies.push_back(paint_and_predict(c));
      items_sent++;
      if (c.op == OP_GET) reads_sent++;
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 30);
         if ($urandom_range(0, 3) == 0) gap = 0;
         else gap = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Sender holds off until every owed reply is back.
   task automatic drain_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (predicted_replies.size() != 0);
   endtask

   // Writes all three registers back to back; optionally pokes the unused index too.
   // Only called with the engine idle.
   task automatic program_frame(input logic [7:0] w, h, en, input bit spare = 1'b0);
      csr_write <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_data  <= w;
      @(posedge clock);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_data  <= h;
      @(posedge clock);
      csr_index <= CSR_DRAW_ENABLE;
      csr_data  <= en;
      @(posedge clock);
      if (spare) begin
         csr_index <= CSR_SPARE;
         csr_data  <= 8'hFF;
         @(posedge clock);
      end
      csr_write     <= 1'b0;
      shadow_width  = w;
      shadow_height = h;
      shadow_enable = en[0];
      frame_settings++;
   endtask

   // Mostly inside the frame, sometimes on the edge just past it, rarely anywhere.
   function automatic logic [15:0] pick_coord(input int unsigned lim);
      case ($urandom_range(0, 15))
         0:       return 16'($urandom_range(0, 16'hFFFF));
         1:       return 16'(lim);
         2:       return (lim == 0) ? 16'd0 : 16'(lim - 1);
         default: return 16'($urandom_range(0, lim + 1));
      endcase
   endfunction

   // Large frames get small boxes so the run stays short; a few boxes are huge.
   function automatic logic [15:0] pick_extent(input int unsigned lim, input bit big);
      if ($urandom_range(0, big ? 99 : 19) == 0) return 16'($urandom_range(0, 16'hFFFF));
      if (big) return 16'($urandom_range(0, 12));
      return 16'($urandom_range(0, lim + 3));
   endfunction

   function automatic draw_cmd_type random_item(input traffic_type kind);
      draw_cmd_type c;
      int unsigned  fw;
      int unsigned  fh;
      int unsigned  pick;
      bit           big;
      fw   = visible_width();
      fh   = visible_height();
      big  = (fw * fh > 1024);
      pick = $urandom_range(0, 99);
      c.color = $urandom();
      if (kind == TRAFFIC_NOISE) begin
         c.op = 3'($urandom_range(0, 7));
         c.x  = 16'($urandom_range(0, 16'hFFFF));
         c.y  = 16'($urandom_range(0, 16'hFFFF));
         c.w  = 16'($urandom_range(0, 16'hFFFF));
         c.h  = 16'($urandom_range(0, 16'hFFFF));
      end else begin
         case (kind)
            TRAFFIC_PIXEL:   c.op = (pick < 50) ? OP_PUT : OP_GET;
            TRAFFIC_RECT:    c.op = (pick < 70) ? OP_FILL : (pick < 90) ? OP_GET : OP_PUT;
            TRAFFIC_OUTLINE: c.op = (pick < 70) ? OP_OUTLINE : OP_GET;
            default: begin
               if (pick < 25)      c.op = OP_PUT;
               else if (pick < 55) c.op = OP_GET;
               else if (pick < 58) c.op = OP_CLEAR;
               else if (pick < 76) c.op = OP_FILL;
               else if (pick < 94) c.op = OP_OUTLINE;
               else                c.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            end
         endcase
         c.x = pick_coord(fw);
         c.y = pick_coord(fh);
         c.w = pick_extent(fw, big);
         c.h = pick_extent(fh, big);
      end
      // a clear of a large frame costs the whole store; keep only a few
      if (c.op == OP_CLEAR && big && $urandom_range(0, 19) != 0) c.op = OP_FILL;
      return c;
   endfunction

   task automatic run_items(input int unsigned n, input traffic_type kind);
      repeat (n) send_cmd(random_item(kind));
   endtask

   // New random geometry: mostly small frames, some empty, some past the store limit.
   task automatic start_random_phase(input bit enabled);
      logic [7:0]  w;
      logic [7:0]  h;
      logic [7:0]  en;
      int unsigned shape;
      drain_replies();
      shape = $urandom_range(0, 15);
      if (shape == 0) begin
         w = 8'($urandom_range(0, 24));
         h = 8'($urandom_range(0, 24));
         if ($urandom_range(0, 1) == 0) w = '0;
         else h = '0;
      end else if (shape == 1) begin
         w = 8'($urandom_range(128, 255));
         h = 8'($urandom_range(128, 255));
      end else if (shape == 2) begin
         w = 8'($urandom_range(64, 128));
         h = 8'($urandom_range(64, 128));
      end else begin
         w = 8'($urandom_range(1, 24));
         h = 8'($urandom_range(1, 24));
      end
      en    = 8'($urandom_range(0, 255));
      en[0] = enabled;
      program_frame(w, h, en);
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_edge_cases();
      // still disabled from reset: a put must do nothing
      send_cmd(draw_item(OP_PUT, 0, 0, 1, 1, 32'hFFFF_FFFF));
      drain_replies();
      program_frame(8'd16, 8'd12, 8'h01);
      send_cmd(draw_item(OP_GET, 0, 0, 0, 0, 32'h0));
      send_cmd(draw_item(OP_PUT, 0, 0, 0, 0, 32'hFFFF_FFFF));
      send_cmd(draw_item(OP_PUT, 15, 11, 0, 0, 32'h5A5A_A5A5));
      send_cmd(draw_item(OP_GET, 15, 11, 0, 0, 32'h0));
      // points just past the right and bottom edges, and at the far corner of the range
      send_cmd(draw_item(OP_PUT, 16, 0, 0, 0, 32'h0000_0001));
      send_cmd(draw_item(OP_GET, 0, 12, 0, 0, 32'h0));
      send_cmd(draw_item(OP_PUT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
      // undefined opcodes are no-ops
      send_cmd(draw_item(OP_SPARE_LO, 1, 1, 4, 4, 32'hFFFF_FFFF));
      send_cmd(draw_item(OP_SPARE_MID, 2, 2, 4, 4, 32'h0F0F_0F0F));
      send_cmd(draw_item(OP_SPARE_HI, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
      // overhanging fill is cut at the edges; one starting outside does nothing
      send_cmd(draw_item(OP_FILL, 10, 8, 16'hFFFF, 16'hFFFF, 32'h1234_5678));
      send_cmd(draw_item(OP_FILL, 16, 3, 2, 2, 32'hDEAD_BEEF));
      send_cmd(draw_item(OP_FILL, 2, 2, 0, 5, 32'hCAFE_0001));
      // empty, normal, overhanging and single-pixel outlines
      send_cmd(draw_item(OP_OUTLINE, 1, 1, 0, 4, 32'hCAFE_0002));
      send_cmd(draw_item(OP_OUTLINE, 3, 2, 5, 4, 32'h0BAD_F00D));
      send_cmd(draw_item(OP_OUTLINE, 14, 10, 5, 5, 32'h7777_8888));
      send_cmd(draw_item(OP_OUTLINE, 0, 0, 1, 1, 32'h0));
      send_cmd(draw_item(OP_GET, 14, 10, 0, 0, 32'h0));
      send_cmd(draw_item(OP_GET, 4, 3, 0, 0, 32'h0));
      // zero-width frame: clear writes nothing
      drain_replies();
      program_frame(8'd0, 8'd12, 8'h01);
      send_cmd(draw_item(OP_CLEAR, 0, 0, 0, 0, 32'h3C3C_3C3C));
      send_cmd(draw_item(OP_GET, 0, 0, 0, 0, 32'h0));
      // oversized registers saturate to the full store
      drain_replies();
      program_frame(8'hFF, 8'hFF, 8'h01, 1'b1);
      send_cmd(draw_item(OP_FILL, 120, 120, 16'hFFFF, 16'hFFFF, 32'h5555_AAAA));
      send_cmd(draw_item(OP_GET, 127, 127, 0, 0, 32'h0));
      send_cmd(draw_item(OP_CLEAR, 0, 0, 0, 0, 32'hA5A5_A5A5));
      // pitch change keeps the store; only the mapping moves
      drain_replies();
      program_frame(8'd8, 8'd4, 8'h01);
      send_cmd(draw_item(OP_GET, 7, 3, 0, 0, 32'h0));
      // enable byte with bit 0 clear turns everything off
      drain_replies();
      program_frame(8'd8, 8'd4, 8'hFE);
      send_cmd(draw_item(OP_PUT, 0, 0, 0, 0, 32'h1111_2222));
      send_cmd(draw_item(OP_GET, 0, 0, 0, 0, 32'h0));
   endtask

   task automatic test_pixel_traffic();
      repeat (3) begin
         start_random_phase(1'b1);
         run_items(100, TRAFFIC_PIXEL);
      end
   endtask

   task automatic test_rect_fills();
      repeat (3) begin
         start_random_phase(1'b1);
         run_items(100, TRAFFIC_RECT);
      end
   endtask

   task automatic test_outlines();
      repeat (3) begin
         start_random_phase(1'b1);
         run_items(100, TRAFFIC_OUTLINE);
      end
   endtask

   task automatic test_disabled_noise();
      start_random_phase(1'b0);
      run_items(30, TRAFFIC_NOISE);
      start_random_phase(1'b1);
      run_items(30, TRAFFIC_NOISE);
   endtask

   task automatic test_mixed_soak();
      for (int i = 0; i < 9; i++) begin
         start_random_phase($urandom_range(0, 7) != 0);
         if (i == 4) begin
            // hold the sender mid-phase until the engine has answered everything
            run_items(55, TRAFFIC_MIX);
            drain_replies();
            run_items(55, TRAFFIC_MIX);
         end else begin
            run_items(110, TRAFFIC_MIX);
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_edge_cases();
      test_pixel_traffic();
      test_rect_fills();
      test_outlines();
      test_disabled_noise();
      test_mixed_soak();

      drain_replies();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (predicted_replies.size() != 0)
         flag_error($sformatf("%0d replies never arrived", predicted_replies.size()));

      $display("Summary: %0d commands (%0d pixel reads) over %0d register settings,",
               items_sent, reads_sent, frame_settings);
      $display("         %0d replies compared, %0d mismatches", replies_checked, fail_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### clipped_rect_fill_engine_unit.f
src/crfe_pkg.sv
src/clipped_rect_fill_engine_unit.sv
tb/sv/tb_clipped_rect_fill_engine_unit.sv
